@@ rtl/cfbc_pkg.sv @@
// Shared constants, codes and types for the chained free-block cache.
// Used by every module of the block and by the port checker; depends on nothing.
package cfbc_pkg;

    // Cache geometry
    localparam int CACHE_ENTRIES = 50;
    localparam int BLOCK_BITS    = 24;
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
    localparam int ADDR_W        = $clog2(CACHE_ENTRIES);
    localparam int TOT_W         = 26;

    // Stream widths
    localparam int IN_USER_W  = 2;
    localparam int IN_DATA_W  = ((BLOCK_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 5;
    localparam int OUT_FLD_W  = 2 * BLOCK_BITS + TOT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Command codes on the input tuser
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_REFILL = 2'd2;

    // Result kinds on the output tuser
    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_SPILL  = 2'd2;
    localparam logic [1:0] KIND_REFILL = 2'd3;

    // Request from the sequencer to the stack memory
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [BLOCK_BITS-1:0] wr_data;
    } ram_req_t;

    // One result word
    typedef struct packed {
        logic [1:0]            kind;
        logic [BLOCK_BITS-1:0] value;
        logic [BLOCK_BITS-1:0] spill;
        logic                  last;
        logic                  need;
        logic                  oos;
        logic                  perr;
        logic [TOT_W-1:0]      total;
    } res_t;

endpackage

@@ rtl/chained_free_block_cache_unit.sv @@
// Chained free-block cache: allocate/free stack with chunk refill and spill.
// Free, refill and rejected commands give their word in the cycle after acceptance;
// an allocate first waits for the registered stack memory read.
// Throughput, while the output is not stalled: 1 item per cycle for free/refill;
// an allocate or a spill holds off the input, and a spill gives one word per cycle.
// Reset (rst_n, asynchronous, active low) empties the stack and zeroes the total.
module chained_free_block_cache_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // block_number [23:0]
    input  logic [cfbc_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd [1:0]
    input  logic [cfbc_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // value [23:0], spill_block [47:24], free_total [73:48], zero pad [79:74]
    output logic [cfbc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // kind [1:0], refill_needed [2], out_of_space [3], protocol_error [4]
    output logic [cfbc_pkg::OUT_USER_W-1:0]    m_tuser,
    output logic                               m_tlast
);
    import cfbc_pkg::*;

    ram_req_t              ram_req;
    logic [BLOCK_BITS-1:0] ram_rd_data;
    res_t                  res;

    cfbc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_word     (s_tdata[BLOCK_BITS-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    cfbc_stack_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    // Pack the result word onto the stream
    assign m_tdata = {(OUT_DATA_W - OUT_FLD_W)'(0), res.total, res.spill, res.value};
    assign m_tuser = {res.perr, res.oos, res.need, res.kind};
    assign m_tlast = res.last;

endmodule

@@ rtl/cfbc_stack_ram.sv @@
// Single-port-write, single-port-read memory holding the in-core free stack.
// Read data is registered and held until the next read. Depends on cfbc_pkg.
module cfbc_stack_ram (
    input  logic                          clk,
    input  cfbc_pkg::ram_req_t            req,
    output logic [cfbc_pkg::BLOCK_BITS-1:0] rd_data
);
    import cfbc_pkg::*;

    logic [BLOCK_BITS-1:0] mem [CACHE_ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port, holds its value between reads
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

@@ rtl/cfbc_ctrl.sv @@
// Sequencer of the free-block cache: decodes commands, drives the stack memory,
// walks it on a spill and owns the output word register. Depends on cfbc_pkg.
module cfbc_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_cmd,
    input  logic [cfbc_pkg::BLOCK_BITS-1:0]   in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cfbc_pkg::res_t                    out_res,
    output cfbc_pkg::ram_req_t                ram_req,
    input  logic [cfbc_pkg::BLOCK_BITS-1:0]   ram_rd_data
);
    import cfbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ALLOC = 3'b010,
        ST_SPILL = 3'b100
    } state_t;

    state_t                state_reg,     state_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic [TOT_W-1:0]      total_reg,     total_next;
    logic                  pend_reg,      pend_next;
    logic [CNT_W-1:0]      pos_reg,       pos_next;
    logic [ADDR_W-1:0]     idx_reg,       idx_next;
    logic [BLOCK_BITS-1:0] spill_blk_reg, spill_blk_next;
    logic                  out_vld_reg,   out_vld_next;
    res_t                  res_reg,       res_next;

    logic                  out_free;
    logic                  accept;
    logic                  load;
    res_t                  res_new;
    logic [CNT_W-1:0]      count_m1;
    logic [CNT_W-1:0]      pos_m1;
    logic                  cnt_over;
    logic [CNT_W-1:0]      cnt_sat;

    assign out_free  = !out_vld_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_vld_reg;
    assign out_res   = res_reg;

    assign count_m1 = count_reg - 1'b1;
    assign pos_m1   = pos_reg - 1'b1;
    assign cnt_over = in_word > BLOCK_BITS'(CACHE_ENTRIES);
    assign cnt_sat  = cnt_over ? CNT_W'(CACHE_ENTRIES) : in_word[CNT_W-1:0];

    // Command decode, stack access and result formation
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        pend_next      = pend_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        spill_blk_next = spill_blk_reg;
        load           = 1'b0;
        res_new        = '0;
        ram_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load      = 1'b1;
                    res_new.last = 1'b1;
                    case (in_cmd)
                        CMD_ALLOC:
                        begin
                            res_new.kind = KIND_ALLOC;
                            if (pend_reg || count_reg == '0)
                            begin
                                res_new.perr = 1'b1;
                            end
                            else
                            begin
                                // Result waits for the top entry to come back
                                load            = 1'b0;
                                count_next      = count_m1;
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = count_m1[ADDR_W-1:0];
                                state_next      = ST_ALLOC;
                            end
                        end
                        CMD_FREE:
                        begin
                            res_new.kind = KIND_FREE;
                            if (pend_reg)
                            begin
                                res_new.perr = 1'b1;
                            end
                            else
                            begin
                                total_next = total_reg + TOT_W'(in_word != '0);
                                if (count_reg >= CNT_W'(CACHE_ENTRIES))
                                begin
                                    // Full: spill the count word now, entries follow
                                    res_new.kind    = KIND_SPILL;
                                    res_new.value   = BLOCK_BITS'(CACHE_ENTRIES);
                                    res_new.spill   = in_word;
                                    res_new.last    = 1'b0;
                                    spill_blk_next  = in_word;
                                    idx_next        = '0;
                                    ram_req.rd_en   = 1'b1;
                                    ram_req.rd_addr = '0;
                                    state_next      = ST_SPILL;
                                end
                                else
                                begin
                                    ram_req.wr_en   = 1'b1;
                                    ram_req.wr_addr = count_reg[ADDR_W-1:0];
                                    ram_req.wr_data = in_word;
                                    count_next      = count_reg + 1'b1;
                                end
                            end
                        end
                        CMD_REFILL:
                        begin
                            res_new.kind = KIND_REFILL;
                            if (!pend_reg)
                            begin
                                res_new.perr = 1'b1;
                            end
                            else if (pos_reg == '0)
                            begin
                                // Count word of the chained chunk
                                res_new.value = BLOCK_BITS'(cnt_sat);
                                res_new.perr  = cnt_over;
                                count_next    = cnt_sat;
                                if (cnt_sat == '0)
                                begin
                                    pend_next = 1'b0;
                                end
                                else
                                begin
                                    pos_next = CNT_W'(1);
                                end
                            end
                            else
                            begin
                                res_new.value   = in_word;
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = pos_m1[ADDR_W-1:0];
                                ram_req.wr_data = in_word;
                                pos_next        = pos_reg + 1'b1;
                                if (pos_reg >= count_reg)
                                begin
                                    pend_next = 1'b0;
                                    pos_next  = '0;
                                end
                            end
                        end
                        default:
                        begin
                            res_new.kind = KIND_REFILL;
                            res_new.perr = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    res_new.kind = KIND_ALLOC;
                    res_new.last = 1'b1;
                    state_next   = ST_IDLE;
                    if (ram_rd_data == '0)
                    begin
                        // Popped the list terminator
                        res_new.oos = 1'b1;
                        count_next  = '0;
                    end
                    else
                    begin
                        res_new.value = ram_rd_data;
                        total_next    = total_reg - 1'b1;
                        if (count_reg == '0)
                        begin
                            res_new.need = 1'b1;
                            pend_next    = 1'b1;
                            pos_next     = '0;
                        end
                    end
                end
            end
            ST_SPILL:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    res_new.kind  = KIND_SPILL;
                    res_new.value = ram_rd_data;
                    res_new.spill = spill_blk_reg;
                    if (idx_reg == ADDR_W'(CACHE_ENTRIES - 1))
                    begin
                        // Last entry out: the freed block becomes the only entry
                        res_new.last    = 1'b1;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = '0;
                        ram_req.wr_data = spill_blk_reg;
                        count_next      = CNT_W'(1);
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        idx_next        = idx_reg + 1'b1;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_new.total = total_next;
    end

    // Output word register
    always_comb
    begin
        out_vld_next = out_vld_reg && !out_ready;
        res_next     = res_reg;
        if (load)
        begin
            out_vld_next = 1'b1;
            res_next     = res_new;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            pend_reg    <= 1'b0;
            pos_reg     <= '0;
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            pend_reg    <= pend_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        spill_blk_reg <= spill_blk_next;
        res_reg       <= res_next;
    end

endmodule

@@ rtl/cfbc_checker.sv @@
// Port-level checker for the chained free-block cache, bound to the top level.
// Depends on cfbc_pkg and the top level's port names.
module cfbc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [cfbc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [cfbc_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [cfbc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic [cfbc_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               m_tlast
);
    import cfbc_pkg::*;

    // A stalled output word holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // No new input is taken while a spill is still streaming out
    a_spill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == KIND_SPILL && !m_tlast |-> !s_tready)
        else $error("input accepted in the middle of a spill");

    // Out of space gives a zero block and no other flag
    a_oos_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tdata[BLOCK_BITS-1:0] == '0 && !m_tuser[2]
            && !m_tuser[4] && m_tuser[1:0] == KIND_ALLOC)
        else $error("out of space word carries a block or other flags");

    // After an accept either a word is shown or the input is held off
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid || !s_tready)
        else $error("accepted word neither answered nor in progress");

endmodule

bind chained_free_block_cache_unit cfbc_checker u_cfbc_checker (.*);

@@ bench/cfbc_result_checker.sv @@
// Result checker for the chained free-block cache: watches both stream ports,
// predicts every result word from the accepted commands and compares them.
// Depends on cfbc_pkg for widths, command codes and result kinds.
module cfbc_result_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // block_number [23:0]
    input  logic [cfbc_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd [1:0]
    input  logic [cfbc_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // value [23:0], spill_block [47:24], free_total [73:48], zero pad [79:74]
    input  logic [cfbc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // kind [1:0], refill_needed [2], out_of_space [3], protocol_error [4]
    input  logic [cfbc_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               m_tlast,
    output int                                 mismatch_count,
    output int                                 words_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cfbc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Own copy of the allocator state
    logic [BLOCK_BITS-1:0] stack_mem [CACHE_ENTRIES];
    int                    stack_depth   = 0;
    logic [TOT_W-1:0]      running_total = '0;
    bit                    refill_wait   = 1'b0;
    int                    refill_pos    = 0;

    // Result words still to come, oldest first
    res_t expected_words [$];

    function automatic string describe(res_t w);
        return $sformatf("kind %0d value %h spill %h last %b need %b oos %b perr %b total %h",
                         w.kind, w.value, w.spill, w.last, w.need, w.oos, w.perr, w.total);
    endfunction

    // Queue one expected word; the free total is taken after the state update.
    task automatic queue_word(input logic [1:0] kind, input logic [BLOCK_BITS-1:0] value,
                              input logic [BLOCK_BITS-1:0] spill, input logic last,
                              input logic need, input logic oos, input logic perr);
        res_t w;
        w.kind  = kind;
        w.value = value;
        w.spill = spill;
        w.last  = last;
        w.need  = need;
        w.oos   = oos;
        w.perr  = perr;
        w.total = running_total;
        expected_words.push_back(w);
    endtask

    // Work out the result words caused by one accepted command word.
    task automatic predict_word(input logic [1:0] cmd, input logic [BLOCK_BITS-1:0] bn);
        logic [BLOCK_BITS-1:0] popped;
        logic                  saturated;
        int                    n;
        case (cmd)
            CMD_ALLOC:
            begin
                if (refill_wait || stack_depth == 0)
                begin
                    queue_word(KIND_ALLOC, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1);
                end
                else
                begin
                    stack_depth--;
                    popped = stack_mem[stack_depth];
                    if (popped == '0)
                    begin
                        // The terminator: the list is exhausted.
                        stack_depth = 0;
                        queue_word(KIND_ALLOC, '0, '0, 1'b1, 1'b0, 1'b1, 1'b0);
                    end
                    else
                    begin
                        running_total = running_total - 1'b1;
                        if (stack_depth == 0)
                        begin
                            refill_wait = 1'b1;
                            refill_pos  = 0;
                        end
                        queue_word(KIND_ALLOC, popped, '0, 1'b1, stack_depth == 0,
                                   1'b0, 1'b0);
                    end
                end
            end
            CMD_FREE:
            begin
                if (refill_wait)
                begin
                    queue_word(KIND_FREE, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1);
                end
                else
                begin
                    if (bn != '0)
                        running_total = running_total + 1'b1;
                    if (stack_depth >= CACHE_ENTRIES)
                    begin
                        // Full stack: spill count and all entries into the freed block.
                        queue_word(KIND_SPILL, BLOCK_BITS'(CACHE_ENTRIES), bn, 1'b0,
                                   1'b0, 1'b0, 1'b0);
                        for (int i = 0; i < CACHE_ENTRIES; i++)
                            queue_word(KIND_SPILL, stack_mem[i], bn, i == CACHE_ENTRIES - 1,
                                       1'b0, 1'b0, 1'b0);
                        stack_mem[0] = bn;
                        stack_depth  = 1;
                    end
                    else
                    begin
                        stack_mem[stack_depth] = bn;
                        stack_depth++;
                        queue_word(KIND_FREE, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
                    end
                end
            end
            default:
            begin
                if (cmd == CMD_REFILL && refill_wait && refill_pos == 0)
                begin
                    // Chunk count, saturated at the cache size.
                    saturated   = bn > CACHE_ENTRIES;
                    n           = saturated ? CACHE_ENTRIES : int'(bn);
                    stack_depth = n;
                    if (n == 0)
                        refill_wait = 1'b0;
                    else
                        refill_pos = 1;
                    queue_word(KIND_REFILL, BLOCK_BITS'(n), '0, 1'b1, 1'b0, 1'b0, saturated);
                end
                else if (cmd == CMD_REFILL && refill_wait)
                begin
                    stack_mem[refill_pos - 1] = bn;
                    refill_pos++;
                    if (refill_pos - 1 >= stack_depth)
                    begin
                        refill_wait = 1'b0;
                        refill_pos  = 0;
                    end
                    queue_word(KIND_REFILL, bn, '0, 1'b1, 1'b0, 1'b0, 1'b0);
                end
                else
                begin
                    // Stray refill word or unused command.
                    queue_word(KIND_REFILL, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1);
                end
            end
        endcase
    endtask

    // Compare one accepted result word with the oldest expectation.
    task automatic check_word();
        res_t seen;
        res_t want;
        seen.kind  = m_tuser[1:0];
        seen.need  = m_tuser[2];
        seen.oos   = m_tuser[3];
        seen.perr  = m_tuser[4];
        seen.last  = m_tlast;
        seen.value = m_tdata[BLOCK_BITS-1:0];
        seen.spill = m_tdata[2*BLOCK_BITS-1:BLOCK_BITS];
        seen.total = m_tdata[2*BLOCK_BITS+TOT_W-1:2*BLOCK_BITS];
        if (expected_words.size() == 0)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("[%0t] unexpected word: %s", $realtime, describe(seen));
            mismatch_count++;
            return;
        end
        want = expected_words.pop_front();
        if (seen.kind !== want.kind || seen.value !== want.value
            || seen.spill !== want.spill || seen.last !== want.last
            || seen.need !== want.need || seen.oos !== want.oos
            || seen.perr !== want.perr || seen.total !== want.total)
        begin
            if (mismatch_count < REPORT_LIMIT)
            begin
                $display("[%0t] word mismatch", $realtime);
                $display("    expected %s", describe(want));
                $display("    actual   %s", describe(seen));
            end
            mismatch_count++;
        end
    endtask

    // Commands are predicted before results are checked; a result never
    // leaves on the same edge as the command that causes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_depth   = 0;
            running_total = '0;
            refill_wait   = 1'b0;
            refill_pos    = 0;
            expected_words.delete();
            mismatch_count = 0;
            words_outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_word(s_tuser[1:0], s_tdata[BLOCK_BITS-1:0]);
            if (m_tvalid && m_tready)
                check_word();
            words_outstanding <= expected_words.size();
        end
    end

endmodule

@@ bench/tb_chained_free_block_cache_unit.sv @@
// Top of the chained free-block cache testbench: clock, reset, command stimulus
// with random gaps, a stalling result sink and the final verdict.
// Depends on cfbc_pkg, the block itself and cfbc_result_checker.
module tb_chained_free_block_cache_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cfbc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 145;
    localparam int QUIET_ITEMS  = 25;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES  = 8;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    int   mismatch_count;
    int   words_outstanding;
    int   cycle_count = 0;
    logic quiet       = 1'b0;

    // Stimulus bookkeeping: a rough picture of the stack used to shape sequences
    logic [BLOCK_BITS-1:0] pool [$];
    bit   refill_open = 1'b0;
    int   refill_left = -1;
    bit   idle_on     = 1'b1;
    bit   sat_done    = 1'b0;
    int   items_sent  = 0;
    int   quiet_at    = 0;

    // Sink state
    int   stall_left  = 0;
    int   sink_phase  = 0;
    bit   sink_busy   = 1'b1;

    chained_free_block_cache_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    cfbc_result_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result sink: random stall bursts, with calm phases in between.
    always @(posedge clk)
    begin
        sink_phase <= sink_phase + 1;
        if (sink_phase % 64 == 63)
            sink_busy <= ($urandom_range(0, 3) != 0);
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (sink_busy && !quiet && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Block number with the extremes well represented.
    function automatic logic [BLOCK_BITS-1:0] pick_block();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return BLOCK_BITS'($urandom_range(1, 100));
        return BLOCK_BITS'($urandom);
    endfunction

    // Chunk count: mostly small, sometimes empty, full or oversized.
    function automatic logic [BLOCK_BITS-1:0] pick_refill_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 12)
            return BLOCK_BITS'(CACHE_ENTRIES);
        if (r < 15)
            return BLOCK_BITS'($urandom_range(CACHE_ENTRIES + 1, 255));
        return BLOCK_BITS'($urandom_range(1, 6));
    endfunction

    // A command that the block must reject while a refill is open.
    function automatic logic [1:0] pick_stray_cmd();
        case ($urandom_range(0, 2))
            0:       return CMD_ALLOC;
            1:       return CMD_FREE;
            default: return CMD_UNUSED;
        endcase
    endfunction

    // Offer one command word, optionally after a gap, and wait for acceptance.
    task automatic send_word(input logic [1:0] cmd, input logic [BLOCK_BITS-1:0] bn);
        logic [BLOCK_BITS-1:0] top_block;
        if (idle_on && !quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_DATA_W'(bn);
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (items_sent % 20 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
        // The closing stretch of the run goes without idling on either side.
        if (quiet_at > 0 && items_sent >= quiet_at)
            quiet <= 1'b1;

        // Follow the stack so that later sequences can be well formed.
        case (cmd)
            CMD_ALLOC:
            begin
                if (!refill_open && pool.size() > 0)
                begin
                    top_block = pool.pop_back();
                    if (top_block == '0)
                    begin
                        pool.delete();
                    end
                    else if (pool.size() == 0)
                    begin
                        refill_open = 1'b1;
                        refill_left = -1;
                    end
                end
            end
            CMD_FREE:
            begin
                if (!refill_open)
                begin
                    if (pool.size() >= CACHE_ENTRIES)
                        pool.delete();
                    pool.push_back(bn);
                end
            end
            CMD_REFILL:
            begin
                if (refill_open)
                begin
                    if (refill_left < 0)
                    begin
                        refill_left = (bn > CACHE_ENTRIES) ? CACHE_ENTRIES : int'(bn);
                    end
                    else
                    begin
                        pool.push_back(bn);
                        refill_left--;
                    end
                    if (refill_left == 0)
                        refill_open = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Hold the input idle until every predicted word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (words_outstanding != 0);
    endtask

    initial
    begin
        int  random_start;
        int  r;
        bit  paused;
        bit  spilled;
        paused  = 1'b0;
        spilled = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rejected commands on an empty cache
        send_word(CMD_ALLOC, 24'h000000);
        send_word(CMD_REFILL, 24'h000003);
        send_word(CMD_UNUSED, 24'hFFFFFF);
        // Terminator first, then the largest and the smallest real block
        send_word(CMD_FREE, 24'h000000);
        send_word(CMD_FREE, 24'hFFFFFF);
        send_word(CMD_FREE, 24'h000001);
        send_word(CMD_ALLOC, 24'hFFFFFF);
        send_word(CMD_ALLOC, 24'h000000);
        // Popping the terminator reports out of space
        send_word(CMD_ALLOC, 24'h000000);
        // Last entry popped: the block chains a chunk, then everything else is refused
        send_word(CMD_FREE, 24'h000005);
        send_word(CMD_ALLOC, 24'h000000);
        send_word(CMD_FREE, 24'h000009);
        send_word(CMD_ALLOC, 24'h000000);
        send_word(CMD_UNUSED, 24'h000000);
        // An empty chunk ends the refill at once
        send_word(CMD_REFILL, 24'h000000);
        send_word(CMD_ALLOC, 24'h000000);
        // Two-entry chunk holding the terminator and the largest block
        send_word(CMD_FREE, 24'h000006);
        send_word(CMD_ALLOC, 24'h000000);
        send_word(CMD_REFILL, 24'h000002);
        send_word(CMD_REFILL, 24'h000000);
        send_word(CMD_REFILL, 24'hFFFFFF);
        // Uncounted blocks drive the free total below zero
        send_word(CMD_ALLOC, 24'h000000);
        send_word(CMD_ALLOC, 24'h000000);

        // Random part: mostly well-formed chains, with noise in between
        random_start = items_sent;
        quiet_at     = random_start + RANDOM_ITEMS - QUIET_ITEMS;
        while (items_sent < random_start + RANDOM_ITEMS)
        begin
            if (!paused && items_sent >= random_start + RANDOM_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end

            if (refill_open)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(pick_stray_cmd(), pick_block());
                end
                else if (refill_left < 0)
                begin
                    // The first chunk of the run is oversized and saturates.
                    if (!sat_done)
                    begin
                        sat_done = 1'b1;
                        send_word(CMD_REFILL, '1);
                    end
                    else
                    begin
                        send_word(CMD_REFILL, pick_refill_count());
                    end
                end
                else
                begin
                    send_word(CMD_REFILL, pick_block());
                end
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (!spilled && items_sent > random_start + 100)
                    r = 85;
                if (r < 40)
                begin
                    send_word(CMD_FREE, pick_block());
                end
                else if (r < 75)
                begin
                    send_word(CMD_ALLOC, pick_block());
                end
                else if (r < 83)
                begin
                    // Drain the stack to reach the chunk link or the terminator.
                    repeat (pool.size()) send_word(CMD_ALLOC, pick_block());
                end
                else if (r < 86)
                begin
                    // Fill the stack and free once more to force a spill.
                    while (pool.size() < CACHE_ENTRIES)
                        send_word(CMD_FREE, pick_block());
                    send_word(CMD_FREE, pick_block());
                    spilled = 1'b1;
                end
                else if (r < 93)
                begin
                    send_word(CMD_REFILL, pick_block());
                end
                else
                begin
                    send_word(CMD_UNUSED, pick_block());
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
